FILE: src/assert_macros.svh
// Assertion macros shared by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mme_pkg.sv
// Shared types, codes and constants of the MIDI message encoder.
package mme_pkg;

  // Default bound on collected system exclusive bytes.
  localparam int SYSEX_LIMIT_DEF = 32;
  // Count width in a queued command, enough for the largest limit.
  localparam int SX_CNT_W = 6;
  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  // Input action codes.
  localparam logic [4:0] ACT_NOTE_OFF    = 5'd0;
  localparam logic [4:0] ACT_NOTE_ON     = 5'd1;
  localparam logic [4:0] ACT_POLY_PRESS  = 5'd2;
  localparam logic [4:0] ACT_CONTROL     = 5'd3;
  localparam logic [4:0] ACT_PROGRAM     = 5'd4;
  localparam logic [4:0] ACT_CHAN_PRESS  = 5'd5;
  localparam logic [4:0] ACT_PITCH_BEND  = 5'd6;
  localparam logic [4:0] ACT_SX_START    = 5'd7;
  localparam logic [4:0] ACT_SX_BYTE     = 5'd8;
  localparam logic [4:0] ACT_SX_END      = 5'd9;
  localparam logic [4:0] ACT_QUARTER     = 5'd10;
  localparam logic [4:0] ACT_CLOCK       = 5'd11;
  localparam logic [4:0] ACT_START       = 5'd12;
  localparam logic [4:0] ACT_CONTINUE    = 5'd13;
  localparam logic [4:0] ACT_STOP        = 5'd14;
  localparam logic [4:0] ACT_ACT_SENSE   = 5'd15;

  // Wire bytes.
  localparam logic [7:0] BYTE_SX_START   = 8'hf0;
  localparam logic [7:0] BYTE_SX_END     = 8'hf7;
  localparam logic [7:0] BYTE_QUARTER    = 8'hf1;
  localparam logic [7:0] BYTE_CLOCK      = 8'hf8;
  localparam logic [7:0] BYTE_START      = 8'hfa;
  localparam logic [7:0] BYTE_CONTINUE   = 8'hfb;
  localparam logic [7:0] BYTE_STOP       = 8'hfc;
  localparam logic [7:0] BYTE_ACT_SENSE  = 8'hfe;
  localparam logic [6:0] DATA_MASK       = 7'h7f;

  // Reset value of the running status timeout.
  localparam logic [15:0] TIMEOUT_RESET  = 16'd10;

  // Command kinds passed from front to back.
  localparam logic [1:0] CMD_BYTES = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_DUMP  = 2'd2;

  // One queued command: up to three literal bytes, a store or a dump.
  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          nbytes;
    logic [2:0][7:0]     bytes;
    logic [SX_CNT_W-1:0] cnt;
  } cmd_t;

endpackage

FILE: src/midi_message_encoder_top.sv
// MIDI message encoder: events in, running-status byte stream out.
// First bytes pass from a queue slot through the back's command register to the output register.
// The back part returns to idle between commands; a sysex end reads each buffered byte from
// the buffer's registered read port in a fetch state before it emits that byte.
// A 4-entry command queue lets the front accept requests while the back drains.
// Reset clears running status, timestamps, sysex fill and queue; the sysex buffer is not cleared.
`include "assert_macros.svh"

module midi_message_encoder_top
  import mme_pkg::*;
#(
  parameter int SYSEX_LIMIT = SYSEX_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[3:0], first_data[11:4], second_data[19:12], event_time[51:20], zero pad
  input  logic [55:0] s_axis_tdata,
  // action[4:0]
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic q_push;
  cmd_t q_in;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;
  logic back_idle;

  // Front: classify requests.
  mme_front #(.SYSEX_LIMIT(SYSEX_LIMIT)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_push        (q_push),
    .q_cmd         (q_in),
    .q_full        (q_full)
  );

  // Command queue.
  mme_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back: emit bytes.
  mme_back #(.SYSEX_LIMIT(SYSEX_LIMIT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .idle          (back_idle),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Checks on the front/back split.
  `ASSERT_SAME_CYCLE(a_no_queue_overrun, clk, rst, q_full, !q_push, "push into a full queue")
  `ASSERT_SAME_CYCLE(a_idle_only_after_last, clk, rst, back_idle && m_axis_tvalid, m_axis_tlast, "back idle while a request is unfinished")
  `ASSERT_SAME_CYCLE(a_dump_within_buffer, clk, rst, q_push && q_in.kind == CMD_DUMP, q_in.cnt < SX_CNT_W'(SYSEX_LIMIT), "sysex dump longer than the buffer")
  `ASSERT_NEXT_CYCLE(a_pop_leaves_idle, clk, rst, q_pop && q_head.kind != CMD_STORE, !back_idle, "back ignored a popped command")

endmodule

FILE: src/mme_queue.sv
// Small command queue that decouples the front from the back.
module mme_queue
  import mme_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;

  assign full  = (fill == (Q_AW + 1)'(Q_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

FILE: src/mme_front.sv
// Front part: accepts events, tracks running status and sysex fill, issues commands.
module mme_front
  import mme_pkg::*;
#(
  parameter int SYSEX_LIMIT = SYSEX_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic [4:0]  s_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        q_push,
  output cmd_t        q_cmd,
  input  logic        q_full
);

  localparam int CNT_W = $clog2(SYSEX_LIMIT);

  logic [15:0]      status_timeout;
  logic [7:0]       running_status;
  logic [31:0]      previous_time;
  logic [CNT_W-1:0] sysex_count;
  logic             sysex_overflow;

  logic [7:0]       running_status_next;
  logic [CNT_W-1:0] sysex_count_next;
  logic             sysex_overflow_next;

  logic [4:0]  action;
  logic [3:0]  channel;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [31:0] event_time;
  logic [31:0] gap;
  logic [7:0]  rs_eff;
  logic [7:0]  status;
  logic [7:0]  qf_sum;
  logic        accept;
  logic        push_cmd;

  assign action      = s_axis_tuser;
  assign channel     = s_axis_tdata[3:0];
  assign first_data  = s_axis_tdata[11:4];
  assign second_data = s_axis_tdata[19:12];
  assign event_time  = s_axis_tdata[51:20];

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_push        = accept && push_cmd;

  // Running status survives only a gap within the timeout.
  assign gap    = event_time - previous_time;
  assign rs_eff = (gap > {16'd0, status_timeout}) ? 8'd0 : running_status;
  assign status = {1'b1, action[2:0], channel};
  assign qf_sum = {first_data[3:0], 4'b0000} + second_data;

  // Classify the event and build its command.
  always_comb begin
    running_status_next = rs_eff;
    sysex_count_next    = sysex_count;
    sysex_overflow_next = sysex_overflow;
    push_cmd            = 1'b0;
    q_cmd               = '0;
    q_cmd.kind          = CMD_BYTES;
    case (action)
      ACT_NOTE_OFF, ACT_NOTE_ON, ACT_POLY_PRESS, ACT_CONTROL,
      ACT_PROGRAM, ACT_CHAN_PRESS, ACT_PITCH_BEND: begin
        push_cmd            = 1'b1;
        running_status_next = status;
        if (rs_eff != status) begin
          q_cmd.bytes[0] = status;
          q_cmd.bytes[1] = {1'b0, first_data[6:0] & DATA_MASK};
          q_cmd.bytes[2] = {1'b0, second_data[6:0] & DATA_MASK};
          q_cmd.nbytes   = (action inside {ACT_PROGRAM, ACT_CHAN_PRESS}) ? 2'd2 : 2'd3;
        end else begin
          q_cmd.bytes[0] = {1'b0, first_data[6:0] & DATA_MASK};
          q_cmd.bytes[1] = {1'b0, second_data[6:0] & DATA_MASK};
          q_cmd.nbytes   = (action inside {ACT_PROGRAM, ACT_CHAN_PRESS}) ? 2'd1 : 2'd2;
        end
      end
      ACT_SX_START: begin
        sysex_count_next    = '0;
        sysex_overflow_next = 1'b0;
      end
      ACT_SX_BYTE: begin
        if (sysex_count < CNT_W'(SYSEX_LIMIT - 1)) begin
          push_cmd         = 1'b1;
          q_cmd.kind       = CMD_STORE;
          q_cmd.bytes[0]   = first_data;
          q_cmd.cnt        = SX_CNT_W'(sysex_count);
          sysex_count_next = sysex_count + 1'b1;
        end else begin
          sysex_overflow_next = 1'b1;
        end
      end
      ACT_SX_END: begin
        push_cmd            = !sysex_overflow;
        q_cmd.kind          = CMD_DUMP;
        q_cmd.cnt           = SX_CNT_W'(sysex_count);
        running_status_next = 8'd0;
        sysex_count_next    = '0;
        sysex_overflow_next = 1'b0;
      end
      ACT_QUARTER: begin
        push_cmd            = 1'b1;
        q_cmd.nbytes        = 2'd2;
        q_cmd.bytes[0]      = BYTE_QUARTER;
        q_cmd.bytes[1]      = {1'b0, qf_sum[6:0]};
        running_status_next = 8'd0;
      end
      ACT_CLOCK, ACT_START, ACT_CONTINUE, ACT_STOP, ACT_ACT_SENSE: begin
        push_cmd            = 1'b1;
        q_cmd.nbytes        = 2'd1;
        running_status_next = 8'd0;
        case (action)
          ACT_CLOCK:    q_cmd.bytes[0] = BYTE_CLOCK;
          ACT_START:    q_cmd.bytes[0] = BYTE_START;
          ACT_CONTINUE: q_cmd.bytes[0] = BYTE_CONTINUE;
          ACT_STOP:     q_cmd.bytes[0] = BYTE_STOP;
          default:      q_cmd.bytes[0] = BYTE_ACT_SENSE;
        endcase
      end
      default: begin
      end
    endcase
  end

  // Configuration and event state.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_timeout <= TIMEOUT_RESET;
      running_status <= 8'd0;
      previous_time  <= 32'd0;
      sysex_count    <= '0;
      sysex_overflow <= 1'b0;
    end else begin
      if (cfg_wr_en) status_timeout <= cfg_wr_data;
      if (accept) begin
        running_status <= running_status_next;
        previous_time  <= event_time;
        sysex_count    <= sysex_count_next;
        sysex_overflow <= sysex_overflow_next;
      end
    end
  end

endmodule

FILE: src/mme_back.sv
// Back part: executes queued commands, holds the sysex buffer, drives the byte stream.
module mme_back
  import mme_pkg::*;
#(
  parameter int SYSEX_LIMIT = SYSEX_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       idle,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast
);

  localparam int CNT_W    = $clog2(SYSEX_LIMIT);
  localparam int SX_DEPTH = SYSEX_LIMIT - 1;
  localparam int AW       = (SX_DEPTH > 1) ? $clog2(SX_DEPTH) : 1;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_BYTES = 3'd1;
  localparam logic [2:0] B_HEAD  = 3'd2;
  localparam logic [2:0] B_FETCH = 3'd3;
  localparam logic [2:0] B_EMIT  = 3'd4;
  localparam logic [2:0] B_TAIL  = 3'd5;

  logic [7:0]       sysex_store [SX_DEPTH];
  logic [7:0]       rd_data;
  logic [2:0]       state;
  cmd_t             cmd;
  logic [1:0]       idx;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_inc;
  logic             out_free;
  logic             emit;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign idle     = (state == B_IDLE);
  assign ptr_inc  = ptr + 1'b1;
  assign emit     = out_free && (state inside {B_BYTES, B_HEAD, B_EMIT, B_TAIL});

  // Sysex buffer: written by store commands, read one entry per fetch.
  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == CMD_STORE) begin
      sysex_store[q_head.cnt[AW-1:0]] <= q_head.bytes[0];
    end
    rd_data <= sysex_store[ptr[AW-1:0]];
  end

  // Command sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The output is valid once a byte is loaded and stays so until it is taken.
      if (emit) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cmd <= q_head;
            idx <= 2'd0;
            if (q_head.kind == CMD_BYTES) state <= B_BYTES;
            else if (q_head.kind == CMD_DUMP) state <= B_HEAD;
          end
        end
        B_BYTES: begin
          if (out_free) begin
            m_axis_tdata  <= cmd.bytes[idx];
            m_axis_tlast  <= (idx == cmd.nbytes - 2'd1);
            idx           <= idx + 2'd1;
            if (idx == cmd.nbytes - 2'd1) state <= B_IDLE;
          end
        end
        B_HEAD: begin
          if (out_free) begin
            m_axis_tdata  <= BYTE_SX_START;
            m_axis_tlast  <= 1'b0;
            ptr           <= '0;
            state         <= (cmd.cnt == '0) ? B_TAIL : B_FETCH;
          end
        end
        B_FETCH: begin
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            m_axis_tdata  <= rd_data;
            m_axis_tlast  <= 1'b0;
            ptr           <= ptr_inc;
            state         <= (ptr_inc == cmd.cnt[CNT_W-1:0]) ? B_TAIL : B_FETCH;
          end
        end
        B_TAIL: begin
          if (out_free) begin
            m_axis_tdata  <= BYTE_SX_END;
            m_axis_tlast  <= 1'b1;
            state         <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
